// ===== rtl/ple_pkg.sv =====
package ple_pkg;

   // Size of the list and the widths that follow from it.
   localparam int CAPACITY = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int POS_W    = 8;
   localparam int ELEM_W   = 8;

   // Operation codes carried on the request channel.
   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_DEL    = 2'd1,
      FUNC_GET    = 2'd2,
      FUNC_PRINT  = 2'd3
   } func_type;

   // Result codes carried on the response channel.
   typedef enum logic [1:0] {
      KIND_ELEM    = 2'd0,
      KIND_INVALID = 2'd1,
      KIND_EOL     = 2'd2,
      KIND_FULL    = 2'd3
   } kind_type;

   typedef struct packed {
      func_type               func;
      logic [POS_W-1:0]       position;
      logic [ELEM_W-1:0]      elem_in;
   } req_type;

   typedef struct packed {
      kind_type               kind;
      logic [ELEM_W-1:0]      elem_out;
      logic                   last;
   } rsp_type;

endpackage

// ===== rtl/ple_ram.sv =====
module ple_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/positional_list_engine_top.sv =====
// Ordered list of up to ple_pkg::CAPACITY bytes held in one RAM with a single read
// and a single write port, driven by a small sequencer that moves each element with a
// read state and a write state. The block takes one request at a time and stalls the
// request channel until that request's work is finished. An add at position r moves
// the elements from r up one slot from the tail, then writes the new byte; a delete
// at r moves the later elements down one slot; a get reads one element and a print
// reads each in turn, then the end-of-list marker, both waiting out response stalls;
// an out-of-range position or an add to a full list gives its result directly. Adds
// and deletes are paced by the RAM port pair; gets and prints by the registered read
// ahead of each element result. Results pass through an output register, so the last
// result of a request may wait on the response channel while the next request is
// taken. The store is not cleared at reset; only entries below the count are used.
module positional_list_engine_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ple_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ple_pkg::rsp_type rsp_data
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_ADD_RD   = 8'b0000_0010,
      ST_ADD_WR   = 8'b0000_0100,
      ST_DEL_RD   = 8'b0000_1000,
      ST_DEL_WR   = 8'b0001_0000,
      ST_READ     = 8'b0010_0000,
      ST_DATA_OUT = 8'b0100_0000,
      ST_RESULT   = 8'b1000_0000
   } state_type;

   state_type                      state_ff, state_in;
   logic [ple_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [ple_pkg::COUNT_W-1:0]    idx_ff, idx_in;
   logic [ple_pkg::COUNT_W-1:0]    pos_m1_ff, pos_m1_in;
   logic [ple_pkg::ELEM_W-1:0]     byte_ff, byte_in;
   ple_pkg::func_type              op_ff, op_in;
   ple_pkg::kind_type              res_kind_ff, res_kind_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   ple_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic [ple_pkg::COUNT_W-1:0]    idx_plus;
   logic [ple_pkg::COUNT_W-1:0]    idx_minus;
   logic [ple_pkg::COUNT_W-1:0]    req_pos_m1;
   logic [ple_pkg::POS_W-1:0]      count_ext;
   logic                           pos_ok;
   logic                           add_pos_ok;
   logic                           list_full;
   logic                           can_load;
   logic                           rsp_load;

   logic                           ram_we;
   logic [ple_pkg::ADDR_W-1:0]     ram_waddr;
   logic [ple_pkg::ELEM_W-1:0]     ram_wdata;
   logic [ple_pkg::ADDR_W-1:0]     ram_raddr;
   logic [ple_pkg::ELEM_W-1:0]     ram_rdata;

   ple_ram #(
      .WIDTH (ple_pkg::ELEM_W),
      .DEPTH (ple_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Position checks against the current element count.
   assign count_ext  = ple_pkg::POS_W'(count_ff);
   assign pos_ok     = (req_data.position != '0) && (req_data.position <= count_ext);
   assign add_pos_ok = (req_data.position != '0) &&
                       (req_data.position <= count_ext + ple_pkg::POS_W'(1));
   assign list_full  = (count_ff == ple_pkg::COUNT_W'(ple_pkg::CAPACITY));
   assign req_pos_m1 = ple_pkg::COUNT_W'(req_data.position - ple_pkg::POS_W'(1));

   assign idx_plus  = idx_ff + ple_pkg::COUNT_W'(1);
   assign idx_minus = idx_ff - ple_pkg::COUNT_W'(1);

   // A new result may enter the output register when it is empty or being drained.
   assign can_load = !rsp_valid_ff || !rsp_stall;

   // Read address: the neighbor to move during a shift, otherwise the current index.
   always_comb begin
      case (state_ff)
         ST_ADD_RD: ram_raddr = idx_minus[ple_pkg::ADDR_W-1:0];
         ST_DEL_RD: ram_raddr = idx_plus[ple_pkg::ADDR_W-1:0];
         default:   ram_raddr = idx_ff[ple_pkg::ADDR_W-1:0];
      endcase
   end

   // Sequencer for the four operations.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      pos_m1_in   = pos_m1_ff;
      byte_in     = byte_ff;
      op_in       = op_ff;
      res_kind_in = res_kind_ff;
      ram_we      = 1'b0;
      ram_waddr   = idx_ff[ple_pkg::ADDR_W-1:0];
      ram_wdata   = ram_rdata;
      rsp_load    = 1'b0;
      rsp_data_in = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_data.func;
               byte_in = req_data.elem_in;
               case (req_data.func)
                  ple_pkg::FUNC_ADD: begin
                     if (!add_pos_ok) begin
                        res_kind_in = ple_pkg::KIND_INVALID;
                        state_in    = ST_RESULT;
                     end else if (list_full) begin
                        res_kind_in = ple_pkg::KIND_FULL;
                        state_in    = ST_RESULT;
                     end else begin
                        idx_in    = count_ff;
                        pos_m1_in = req_pos_m1;
                        state_in  = ST_ADD_RD;
                     end
                  end
                  ple_pkg::FUNC_DEL: begin
                     if (!pos_ok) begin
                        res_kind_in = ple_pkg::KIND_INVALID;
                        state_in    = ST_RESULT;
                     end else begin
                        idx_in   = req_pos_m1;
                        state_in = ST_DEL_RD;
                     end
                  end
                  ple_pkg::FUNC_GET: begin
                     if (!pos_ok) begin
                        res_kind_in = ple_pkg::KIND_INVALID;
                        state_in    = ST_RESULT;
                     end else begin
                        idx_in   = req_pos_m1;
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     // Print walks from the head; an empty list gives only the marker.
                     idx_in = '0;
                     if (count_ff == '0) begin
                        res_kind_in = ple_pkg::KIND_EOL;
                        state_in    = ST_RESULT;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
               endcase
            end
         end

         // Insert: move elements up one slot from the tail, then drop in the new byte.
         ST_ADD_RD: begin
            if (idx_ff == pos_m1_ff) begin
               ram_we    = 1'b1;
               ram_wdata = byte_ff;
               count_in  = count_ff + ple_pkg::COUNT_W'(1);
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_ADD_WR;
            end
         end
         ST_ADD_WR: begin
            ram_we   = 1'b1;
            idx_in   = idx_minus;
            state_in = ST_ADD_RD;
         end

         // Delete: move elements down one slot toward the head, then drop the count.
         ST_DEL_RD: begin
            if (idx_plus == count_ff) begin
               count_in = count_ff - ple_pkg::COUNT_W'(1);
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DEL_WR;
            end
         end
         ST_DEL_WR: begin
            ram_we   = 1'b1;
            idx_in   = idx_plus;
            state_in = ST_DEL_RD;
         end

         ST_READ: begin
            state_in = ST_DATA_OUT;
         end

         // The read address holds here, so the read data stays put through a stall.
         ST_DATA_OUT: begin
            if (can_load) begin
               rsp_load             = 1'b1;
               rsp_data_in.kind     = ple_pkg::KIND_ELEM;
               rsp_data_in.elem_out = ram_rdata;
               if (op_ff == ple_pkg::FUNC_GET) begin
                  rsp_data_in.last = 1'b1;
                  state_in         = ST_IDLE;
               end else if (idx_plus == count_ff) begin
                  res_kind_in = ple_pkg::KIND_EOL;
                  state_in    = ST_RESULT;
               end else begin
                  idx_in   = idx_plus;
                  state_in = ST_READ;
               end
            end
         end

         ST_RESULT: begin
            if (can_load) begin
               rsp_load         = 1'b1;
               rsp_data_in.kind = res_kind_ff;
               rsp_data_in.last = 1'b1;
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and the response payload.
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pos_m1_ff   <= pos_m1_in;
      byte_ff     <= byte_in;
      op_ff       <= op_in;
      res_kind_ff <= res_kind_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/ple_checker.sv =====
module ple_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input ple_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ple_pkg::rsp_type rsp_data
);

   // A stalled response keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Every accepted request keeps the block busy for at least the next cycle.
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken on back-to-back cycles");

   // Only element bytes of a print can come ahead of the final result.
   a_nonlast_is_elem: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.kind == ple_pkg::KIND_ELEM)
      else $error("non-final result is not an element");

   // Markers and errors end the request and carry a zero byte.
   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != ple_pkg::KIND_ELEM |->
         rsp_data.last && rsp_data.elem_out == '0)
      else $error("marker result malformed");

endmodule

bind positional_list_engine_top ple_checker u_ple_checker (.*);
